@@ design/lpf_pkg.sv @@
`timescale 1ns / 1ps

package lpf_pkg;

	// route table geometry
	localparam int TABLE_ENTRIES = 64;
	localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int MAX_LEN = 32;
	localparam logic [15:0] RESET_CHECKSUM = 16'd1234;

	// result action codes
	typedef enum logic [2:0] {
		ACT_STORED   = 3'd0,
		ACT_REJECT   = 3'd1,
		ACT_CHECKSUM = 3'd2,
		ACT_EXPIRED  = 3'd3,
		ACT_POLICY   = 3'd4,
		ACT_SEND     = 3'd5,
		ACT_DEFAULT  = 3'd6,
		ACT_UNKNOWN  = 3'd7
	} act_t;

	// operation codes
	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_FORWARD = 1'b1
	} op_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// one stored route
	typedef struct packed {
		logic [31:0] prefix;
		logic [5:0]  len;
		logic [15:0] iface;
	} route_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_rd;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic early;
		logic table_empty;
		logic scan_last;
	} status_t;

	// network mask for a prefix length, lengths of 32 and above give all ones
	function automatic logic [31:0] len_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) begin
			m = 32'd0;
		end else if (len >= 6'(MAX_LEN)) begin
			m = 32'hFFFF_FFFF;
		end else begin
			m = 32'hFFFF_FFFF << (6'(MAX_LEN) - len);
		end
		return m;
	endfunction

endpackage

@@ design/lpf_ctrl.sv @@
`timescale 1ns / 1ps

module lpf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  lpf_pkg::status_t status,
	output lpf_pkg::cmd_t    cmd,
	output logic             busy
);

	lpf_pkg::state_t state_q;
	lpf_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			lpf_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = lpf_pkg::ST_CHECK;
				end
			end
			lpf_pkg::ST_CHECK: begin
				if (status.early || status.table_empty) begin
					state_d = lpf_pkg::ST_FINISH;
				end else begin
					state_d = lpf_pkg::ST_SCAN;
				end
			end
			lpf_pkg::ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (status.scan_last) begin
					state_d = lpf_pkg::ST_DRAIN;
				end
			end
			lpf_pkg::ST_DRAIN: begin
				// last read compares this cycle
				state_d = lpf_pkg::ST_FINISH;
			end
			lpf_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d = lpf_pkg::ST_IDLE;
			end
			default: begin
				state_d = lpf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/lpf_datapath.sv @@
`timescale 1ns / 1ps

module lpf_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  lpf_pkg::cmd_t    cmd,
	output lpf_pkg::status_t status,
	input  logic             config_we,
	input  logic [15:0]      config_data,
	input  logic             operation,
	input  logic [31:0]      rule_prefix,
	input  logic [5:0]       rule_length,
	input  logic [15:0]      rule_interface,
	input  logic [15:0]      checksum_word,
	input  logic [7:0]       time_to_live,
	input  logic [31:0]      dst_address,
	input  logic [31:0]      time_seconds,
	input  logic [19:0]      time_micros,
	output logic             done,
	output logic [2:0]       action,
	output logic [15:0]      out_interface,
	output logic [31:0]      out_seconds,
	output logic [19:0]      out_micros
);

	localparam int N = lpf_pkg::TABLE_ENTRIES;
	localparam int AW = lpf_pkg::ADDR_W;
	localparam int CW = lpf_pkg::CNT_W;

	lpf_pkg::route_t route_mem [N];

	logic [15:0]            good_checksum_q;
	logic [CW-1:0]          count_q;
	logic [15:0]            default_iface_q;
	logic                   default_set_q;

	// latched transaction
	logic                   op_q;
	logic [31:0]            prefix_q;
	logic [31:0]            masked_q;
	logic [5:0]             len_q;
	logic [15:0]            iface_q;
	logic [31:0]            dst_q;
	logic [31:0]            seconds_q;
	logic [19:0]            micros_q;
	logic                   len_bad_q;
	logic                   csum_bad_q;
	logic                   expired_q;

	// scan state
	logic [CW-1:0]          idx_q;
	logic                   rd_valid_s1;
	lpf_pkg::route_t        rd_entry_s1;
	logic                   dup_q;
	logic                   found_q;
	logic [5:0]             best_len_q;
	logic [15:0]            win_iface_q;

	lpf_pkg::act_t          act_d;
	logic [15:0]            oif_d;
	logic                   store_d;
	logic                   table_full;
	logic                   hit;

	assign table_full = (count_q == CW'(N));

	assign status.early = (op_q == lpf_pkg::OP_LOAD) ? len_bad_q : (csum_bad_q | expired_q);
	assign status.table_empty = (count_q == '0);
	assign status.scan_last = (CW'(idx_q + CW'(1)) == count_q);

	// checksum register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_checksum_q <= lpf_pkg::RESET_CHECKSUM;
		end else if (config_we) begin
			good_checksum_q <= config_data;
		end
	end

	// latch the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			prefix_q <= rule_prefix;
			masked_q <= rule_prefix & lpf_pkg::len_mask(rule_length);
			len_q <= rule_length;
			iface_q <= rule_interface;
			dst_q <= dst_address;
			seconds_q <= time_seconds;
			micros_q <= time_micros;
			len_bad_q <= (rule_length > 6'(lpf_pkg::MAX_LEN));
			csum_bad_q <= (checksum_word != good_checksum_q);
			expired_q <= (time_to_live <= 8'd1);
		end
	end

	// table read, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan_rd) begin
				idx_q <= CW'(idx_q + CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			rd_entry_s1 <= route_mem[idx_q[AW-1:0]];
		end
		if (cmd.finish && store_d) begin
			route_mem[count_q[AW-1:0]] <= '{prefix: masked_q, len: len_q, iface: iface_q};
		end
	end

	// compare the entry read last cycle
	assign hit = ((dst_q & lpf_pkg::len_mask(rd_entry_s1.len)) == rd_entry_s1.prefix) &&
		(!found_q || (rd_entry_s1.len > best_len_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q <= 1'b0;
			found_q <= 1'b0;
		end else if (cmd.load) begin
			dup_q <= 1'b0;
			found_q <= 1'b0;
		end else if (rd_valid_s1) begin
			if (op_q == lpf_pkg::OP_LOAD) begin
				if (rd_entry_s1.len == len_q && rd_entry_s1.prefix == masked_q) begin
					dup_q <= 1'b1;
				end
			end else if (hit) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1 && op_q == lpf_pkg::OP_FORWARD && hit) begin
			best_len_q <= rd_entry_s1.len;
			win_iface_q <= rd_entry_s1.iface;
		end
	end

	// final decision
	always_comb begin
		act_d = lpf_pkg::ACT_UNKNOWN;
		oif_d = '0;
		store_d = 1'b0;
		if (op_q == lpf_pkg::OP_LOAD) begin
			if (len_bad_q || dup_q || table_full) begin
				act_d = lpf_pkg::ACT_REJECT;
			end else begin
				act_d = lpf_pkg::ACT_STORED;
				store_d = 1'b1;
			end
		end else if (csum_bad_q) begin
			act_d = lpf_pkg::ACT_CHECKSUM;
		end else if (expired_q) begin
			act_d = lpf_pkg::ACT_EXPIRED;
		end else if (found_q) begin
			if (win_iface_q == '0) begin
				act_d = lpf_pkg::ACT_POLICY;
			end else begin
				act_d = lpf_pkg::ACT_SEND;
				oif_d = win_iface_q;
			end
		end else if (default_set_q) begin
			act_d = lpf_pkg::ACT_DEFAULT;
			oif_d = default_iface_q;
		end
	end

	// table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			default_iface_q <= '0;
			default_set_q <= 1'b0;
		end else if (cmd.finish && store_d) begin
			count_q <= CW'(count_q + CW'(1));
			if (prefix_q == '0) begin
				default_iface_q <= iface_q;
				default_set_q <= 1'b1;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			action <= act_d;
			out_interface <= oif_d;
			out_seconds <= (op_q == lpf_pkg::OP_FORWARD) ? seconds_q : 32'd0;
			out_micros <= (op_q == lpf_pkg::OP_FORWARD) ? micros_q : 20'd0;
		end
	end

endmodule

@@ design/ipv4_longest_prefix_forwarder.sv @@
`timescale 1ns / 1ps
// sequence: start is taken in idle, then check, a scan of the N stored routes, drain, finish;
//   a bad rule length, bad checksum, expired TTL or empty table goes from check to finish
// one transaction at a time: a new start is taken only once the block is back in idle;
//   the table scan reads one entry a cycle over a single read port; no receiver stall
// reset: arst_n clears the route count, default route and controller at once and reloads
//   the checksum register with 1234; no sweep of the table, entries beyond the count
//   are never read

module ipv4_longest_prefix_forwarder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        config_we,
	input  logic [15:0] config_data,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [31:0] rule_prefix,
	input  logic [5:0]  rule_length,
	input  logic [15:0] rule_interface,
	input  logic [15:0] checksum_word,
	input  logic [7:0]  time_to_live,
	input  logic [31:0] dst_address,
	input  logic [31:0] time_seconds,
	input  logic [19:0] time_micros,
	output logic        done,
	output logic [2:0]  action,
	output logic [15:0] out_interface,
	output logic [31:0] out_seconds,
	output logic [19:0] out_micros
);

	lpf_pkg::cmd_t    cmd;
	lpf_pkg::status_t status;

	lpf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	lpf_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.config_we      (config_we),
		.config_data    (config_data),
		.operation      (operation),
		.rule_prefix    (rule_prefix),
		.rule_length    (rule_length),
		.rule_interface (rule_interface),
		.checksum_word  (checksum_word),
		.time_to_live   (time_to_live),
		.dst_address    (dst_address),
		.time_seconds   (time_seconds),
		.time_micros    (time_micros),
		.done           (done),
		.action         (action),
		.out_interface  (out_interface),
		.out_seconds    (out_seconds),
		.out_micros     (out_micros)
	);

	// an accepted transaction keeps the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after start");

	// a result follows a busy cycle and the block is free when it shows
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result strobe outside a transaction");

	// rule results carry no interface and no timestamp
	a_rule_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (action == lpf_pkg::ACT_STORED || action == lpf_pkg::ACT_REJECT)
		|-> out_interface == 16'd0 && out_seconds == 32'd0 && out_micros == 20'd0)
		else $error("rule result with packet fields");

	// only send and default name an interface
	a_oif_only_forward: assert property (@(posedge clk) disable iff (!arst_n)
		done && action != lpf_pkg::ACT_SEND && action != lpf_pkg::ACT_DEFAULT
		|-> out_interface == 16'd0)
		else $error("interface on a non-forwarding result");

endmodule

@@ tb/sv/ipv4_longest_prefix_forwarder_tb.sv @@
`timescale 1ns / 1ps

module ipv4_longest_prefix_forwarder_tb;

	// one request as driven onto the ports
	typedef struct {
		lpf_pkg::op_t op;
		logic [31:0]  prefix;
		logic [5:0]   len;
		logic [15:0]  iface;
		logic [15:0]  csum;
		logic [7:0]   ttl;
		logic [31:0]  dst;
		logic [31:0]  secs;
		logic [19:0]  micros;
	} fwd_req_t;

	// one forwarding decision
	typedef struct {
		lpf_pkg::act_t action;
		logic [15:0]   iface;
		logic [31:0]   secs;
		logic [19:0]   micros;
	} fwd_res_t;

	// route table mirror and queue of expected decisions
	class route_scoreboard;
		logic [31:0] rt_prefix [lpf_pkg::TABLE_ENTRIES];
		logic [5:0]  rt_len    [lpf_pkg::TABLE_ENTRIES];
		logic [15:0] rt_iface  [lpf_pkg::TABLE_ENTRIES];
		int unsigned n_routes;
		logic [15:0] dflt_iface;
		bit          dflt_valid;
		logic [15:0] good_csum;
		fwd_res_t    decisions_q[$];
		int unsigned n_errors;
		int unsigned n_checked;
		int unsigned act_seen[8];

		function new();
			n_routes = 0;
			dflt_iface = 16'd0;
			dflt_valid = 1'b0;
			good_csum = lpf_pkg::RESET_CHECKSUM;
			n_errors = 0;
			n_checked = 0;
			foreach (act_seen[i]) act_seen[i] = 0;
		endfunction

		function logic [31:0] net_mask(logic [5:0] len);
			if (len == 6'd0) return 32'd0;
			return 32'hFFFF_FFFF << (32 - len);
		endfunction

		// a route that is well formed and not yet in the table
		function bit route_is_new(logic [31:0] prefix, logic [5:0] len);
			logic [31:0] masked;
			int i;
			if (len > 6'(lpf_pkg::MAX_LEN)) return 1'b0;
			masked = prefix & net_mask(len);
			for (i = 0; i < n_routes; i++) begin
				if (rt_len[i] == len && rt_prefix[i] == masked) return 1'b0;
			end
			return 1'b1;
		endfunction

		function lpf_pkg::act_t add_route(fwd_req_t r);
			if (!route_is_new(r.prefix, r.len) || n_routes >= lpf_pkg::TABLE_ENTRIES)
				return lpf_pkg::ACT_REJECT;
			rt_prefix[n_routes] = r.prefix & net_mask(r.len);
			rt_len[n_routes] = r.len;
			rt_iface[n_routes] = r.iface;
			n_routes++;
			// zero address also names the default interface, last one wins
			if (r.prefix == 32'd0) begin
				dflt_iface = r.iface;
				dflt_valid = 1'b1;
			end
			return lpf_pkg::ACT_STORED;
		endfunction

		function fwd_res_t forward_packet(fwd_req_t r);
			fwd_res_t res;
			bit hit;
			logic [5:0] best_len;
			logic [15:0] win_iface;
			int i;
			res.action = lpf_pkg::ACT_UNKNOWN;
			res.iface = 16'd0;
			res.secs = r.secs;
			res.micros = r.micros;
			hit = 1'b0;
			best_len = 6'd0;
			win_iface = 16'd0;
			if (r.csum != good_csum) begin
				res.action = lpf_pkg::ACT_CHECKSUM;
			end else if (r.ttl <= 8'd1) begin
				res.action = lpf_pkg::ACT_EXPIRED;
			end else begin
				// longest prefix wins, first entry wins a tie
				for (i = 0; i < n_routes; i++) begin
					if ((r.dst & net_mask(rt_len[i])) == rt_prefix[i] &&
						(!hit || rt_len[i] > best_len)) begin
						hit = 1'b1;
						best_len = rt_len[i];
						win_iface = rt_iface[i];
					end
				end
				if (hit && win_iface == 16'd0) begin
					res.action = lpf_pkg::ACT_POLICY;
				end else if (hit) begin
					res.action = lpf_pkg::ACT_SEND;
					res.iface = win_iface;
				end else if (dflt_valid) begin
					res.action = lpf_pkg::ACT_DEFAULT;
					res.iface = dflt_iface;
				end
			end
			return res;
		endfunction

		function void note_input(fwd_req_t r);
			fwd_res_t res;
			if (r.op == lpf_pkg::OP_LOAD) begin
				res.action = add_route(r);
				res.iface = 16'd0;
				res.secs = 32'd0;
				res.micros = 20'd0;
			end else begin
				res = forward_packet(r);
			end
			decisions_q.insert(decisions_q.size(), res);
		endfunction

		function int pending();
			return decisions_q.size();
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			n_errors++;
		endtask

		task check_result(fwd_res_t got);
			fwd_res_t want;
			if (decisions_q.size() == 0) begin
				report_mismatch($sformatf("result with action %0d but none pending", got.action));
				return;
			end
			want = decisions_q.pop_front();
			n_checked++;
			act_seen[int'(want.action)]++;
			if (got.action !== want.action)
				report_mismatch($sformatf("action %0d, want %0d", got.action, want.action));
			if (got.iface !== want.iface)
				report_mismatch($sformatf("out_interface %0h, want %0h", got.iface, want.iface));
			if (got.secs !== want.secs)
				report_mismatch($sformatf("out_seconds %0h, want %0h", got.secs, want.secs));
			if (got.micros !== want.micros)
				report_mismatch($sformatf("out_micros %0h, want %0h", got.micros, want.micros));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        config_we;
	logic [15:0] config_data;
	logic        start;
	logic        busy;
	logic        operation;
	logic [31:0] rule_prefix;
	logic [5:0]  rule_length;
	logic [15:0] rule_interface;
	logic [15:0] checksum_word;
	logic [7:0]  time_to_live;
	logic [31:0] dst_address;
	logic [31:0] time_seconds;
	logic [19:0] time_micros;
	logic        done;
	logic [2:0]  action;
	logic [15:0] out_interface;
	logic [31:0] out_seconds;
	logic [19:0] out_micros;

	route_scoreboard sb;
	int unsigned     n_sent;

	ipv4_longest_prefix_forwarder i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.config_we      (config_we),
		.config_data    (config_data),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.rule_prefix    (rule_prefix),
		.rule_length    (rule_length),
		.rule_interface (rule_interface),
		.checksum_word  (checksum_word),
		.time_to_live   (time_to_live),
		.dst_address    (dst_address),
		.time_seconds   (time_seconds),
		.time_micros    (time_micros),
		.done           (done),
		.action         (action),
		.out_interface  (out_interface),
		.out_seconds    (out_seconds),
		.out_micros     (out_micros)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// results are taken on the edge that ends the strobe cycle
	always @(posedge clk) begin : sample_results
		fwd_res_t got;
		if (arst_n && done) begin
			got.action = lpf_pkg::act_t'(action);
			got.iface = out_interface;
			got.secs = out_seconds;
			got.micros = out_micros;
			sb.check_result(got);
		end
	end

	// all fields random, callers overwrite what matters
	function automatic fwd_req_t noise_req();
		fwd_req_t r;
		r.op = ($urandom_range(1) == 0) ? lpf_pkg::OP_LOAD : lpf_pkg::OP_FORWARD;
		r.prefix = $urandom();
		r.len = 6'($urandom());
		r.iface = 16'($urandom());
		r.csum = 16'($urandom());
		r.ttl = 8'($urandom());
		r.dst = $urandom();
		r.secs = $urandom();
		r.micros = 20'($urandom());
		return r;
	endfunction

	function automatic fwd_req_t mk_rule(logic [31:0] p, logic [5:0] l, logic [15:0] i);
		fwd_req_t r;
		r = noise_req();
		r.op = lpf_pkg::OP_LOAD;
		r.prefix = p;
		r.len = l;
		r.iface = i;
		return r;
	endfunction

	function automatic fwd_req_t mk_pkt(logic [15:0] c, logic [7:0] t, logic [31:0] d);
		fwd_req_t r;
		r = noise_req();
		r.op = lpf_pkg::OP_FORWARD;
		r.csum = c;
		r.ttl = t;
		r.dst = d;
		return r;
	endfunction

	// mostly valid packets aimed at stored routes, rules nested under stored ones
	function automatic fwd_req_t make_random(bit fill_phase);
		fwd_req_t r;
		int pick;
		int k;
		int base_len;
		r = noise_req();
		r.op = ($urandom_range(99) < 25) ? lpf_pkg::OP_LOAD : lpf_pkg::OP_FORWARD;
		r.len = 6'($urandom_range(1, 32));
		if ($urandom_range(9) == 0) r.iface = 16'd0;
		if ($urandom_range(99) < 82) r.csum = sb.good_csum;
		if ($urandom_range(9) == 0) r.ttl = 8'($urandom_range(1));
		if (r.op == lpf_pkg::OP_FORWARD) begin
			if (sb.n_routes != 0 && $urandom_range(99) < 65) begin
				k = $urandom_range(sb.n_routes - 1);
				r.dst = sb.rt_prefix[k] | (r.dst & ~sb.net_mask(sb.rt_len[k]));
			end
		end else begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				r.len = 6'($urandom_range(33, 63));
			end else if (pick < 20 && sb.n_routes != 0) begin
				k = $urandom_range(sb.n_routes - 1);
				r.len = sb.rt_len[k];
				r.prefix = sb.rt_prefix[k] | (r.prefix & ~sb.net_mask(sb.rt_len[k]));
			end else if (pick < 28) begin
				r.prefix = 32'd0;
			end else if (pick < 65 && sb.n_routes != 0) begin
				k = $urandom_range(sb.n_routes - 1);
				base_len = sb.rt_len[k];
				base_len = base_len + $urandom_range(1, 8);
				if (base_len > lpf_pkg::MAX_LEN) base_len = lpf_pkg::MAX_LEN;
				r.len = 6'(base_len);
				r.prefix = sb.rt_prefix[k] | (r.prefix & ~sb.net_mask(sb.rt_len[k]));
			end else if (fill_phase && pick < 72) begin
				r.len = 6'd0;
			end
			// keep a couple of slots free until the last phase
			if (!fill_phase && sb.n_routes >= lpf_pkg::TABLE_ENTRIES - 2 &&
				sb.route_is_new(r.prefix, r.len))
				r.len = 6'($urandom_range(33, 63));
		end
		return r;
	endfunction

	// present one transaction and hold it until the block takes it
	task drive_req(fwd_req_t r, int idle_pct);
		@(negedge clk);
		start = 1'b1;
		operation = r.op;
		rule_prefix = r.prefix;
		rule_length = r.len;
		rule_interface = r.iface;
		checksum_word = r.csum;
		time_to_live = r.ttl;
		dst_address = r.dst;
		time_seconds = r.secs;
		time_micros = r.micros;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_input(r);
		n_sent++;
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(80)) @(negedge clk);
		end
	endtask

	// wait until every decision is back and the block is idle
	task drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending() != 0 || busy) @(posedge clk);
	endtask

	task write_checksum(logic [15:0] value);
		@(negedge clk);
		config_we = 1'b1;
		config_data = value;
		@(negedge clk);
		config_we = 1'b0;
		sb.good_csum = value;
	endtask

	// run limit
	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : main_seq
		fwd_req_t r;
		logic [15:0] c;
		logic [15:0] phase_csum [5];
		int phase_idle [5];
		int p;
		int i;
		sb = new();
		n_sent = 0;
		arst_n = 1'b0;
		config_we = 1'b0;
		config_data = 16'd0;
		start = 1'b0;
		operation = lpf_pkg::OP_LOAD;
		rule_prefix = 32'd0;
		rule_length = 6'd0;
		rule_interface = 16'd0;
		checksum_word = 16'd0;
		time_to_live = 8'd0;
		dst_address = 32'd0;
		time_seconds = 32'd0;
		time_micros = 20'd0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, checksum register at its reset value
		c = lpf_pkg::RESET_CHECKSUM;
		drive_req(mk_pkt(c, 8'd64, 32'h0A00_0001), 0);     // empty table, no default
		drive_req(mk_pkt(c ^ 16'd1, 8'd64, 32'h0A00_0001), 0);
		drive_req(mk_pkt(c, 8'd0, 32'h0A00_0001), 0);
		drive_req(mk_pkt(c, 8'd1, 32'h0A00_0001), 0);
		drive_req(mk_pkt(~c, 8'd0, 32'h0A00_0001), 0);     // checksum checked before ttl
		r = mk_pkt(c, 8'd255, 32'hFFFF_FFFF);
		r.secs = 32'hFFFF_FFFF;
		r.micros = 20'hF_FFFF;                              // micros beyond one second
		drive_req(r, 0);
		r = mk_pkt(c, 8'd2, 32'd0);
		r.secs = 32'd0;
		r.micros = 20'd0;
		drive_req(r, 0);
		drive_req(mk_rule(32'h1234_5678, 6'd33, 16'd1), 0);
		drive_req(mk_rule(32'h1234_5678, 6'd63, 16'd1), 0);
		drive_req(mk_rule(32'd0, 6'd16, 16'd0), 0);         // default with interface 0
		drive_req(mk_pkt(c, 8'd2, 32'h0102_0304), 0);
		drive_req(mk_rule(32'hC0A8_0000, 6'd16, 16'd5), 0);
		drive_req(mk_rule(32'hC0A8_0155, 6'd24, 16'hFFFF), 0);
		drive_req(mk_rule(32'hC0A8_01FF, 6'd24, 16'd7), 0);  // duplicate after masking
		drive_req(mk_rule(32'hFFFF_FFFF, 6'd32, 16'd0), 0);
		drive_req(mk_rule(32'hFFFF_FFFF, 6'd32, 16'd3), 0);
		drive_req(mk_pkt(c, 8'd64, 32'hC0A8_0102), 0);
		drive_req(mk_pkt(c, 8'd64, 32'hC0A8_0202), 0);
		drive_req(mk_pkt(c, 8'd64, 32'hFFFF_FFFF), 0);
		drive_req(mk_pkt(c, 8'd64, 32'h0000_1234), 0);
		drive_req(mk_rule(32'd0, 6'd8, 16'h0042), 0);       // later default replaces
		drive_req(mk_pkt(c, 8'd64, 32'h0102_0304), 0);
		drive_req(mk_pkt(c, 8'd64, 32'h00FF_0000), 0);
		drive_req(mk_rule(32'h8000_0000, 6'd1, 16'hFFFF), 0);
		drive_req(mk_pkt(c, 8'd64, 32'h8000_0001), 0);

		// random phases, the last one may store zero-length routes and fill the table
		phase_csum = '{16'h0000, 16'hFFFF, 16'($urandom()), 16'($urandom()),
			lpf_pkg::RESET_CHECKSUM};
		phase_idle = '{0, 71, 0, 7, 20};
		for (p = 0; p < 5; p++) begin
			drain();
			write_checksum(phase_csum[p]);
			for (i = 0; i < 285; i++) drive_req(make_random(p == 4), phase_idle[p]);
		end

		drain();
		repeat (20) @(posedge clk);
		$display("%0d transactions sent, %0d results checked, %0d routes left in the table",
			n_sent, sb.n_checked, sb.n_routes);
		$display("actions stored/reject/csum/ttl/policy/send/default/unknown: %0d %0d %0d %0d %0d %0d %0d %0d",
			sb.act_seen[0], sb.act_seen[1], sb.act_seen[2], sb.act_seen[3],
			sb.act_seen[4], sb.act_seen[5], sb.act_seen[6], sb.act_seen[7]);
		if (sb.n_errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
